FILE: sv/dsti_pkg.sv
// ----------------------------------------------------------------------------
// dsti_pkg: shared types and constants for the decimal string parser
// Token codes made by the front classifier and read by the back parser.
// ----------------------------------------------------------------------------
package dsti_pkg;

  // token kinds
  localparam logic [2:0] TK_DIGIT = 3'd0;
  localparam logic [2:0] TK_BLANK = 3'd1;
  localparam logic [2:0] TK_PLUS  = 3'd2;
  localparam logic [2:0] TK_MINUS = 3'd3;
  localparam logic [2:0] TK_OTHER = 3'd4;
  localparam logic [2:0] TK_END   = 3'd5;

  // widths
  localparam int CHAR_W  = 8;
  localparam int MAG_W   = 33;
  localparam int VALUE_W = 32;

  // classified character
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
  } tok_t;

  localparam int TOK_W = $bits(tok_t);

endpackage

FILE: sv/dsti_front.sv
// ----------------------------------------------------------------------------
// dsti_front: character intake and classification
// Registers each accepted character as a token (digit, blank, sign, other,
// end of string) and offers it to the token queue.
// ----------------------------------------------------------------------------
module dsti_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  output logic                      char_ready,
  input  logic [dsti_pkg::CHAR_W-1:0] char_byte,
  output logic                      tok_valid,
  input  logic                      tok_ready,
  output dsti_pkg::tok_t            tok
);
  import dsti_pkg::*;

  tok_t tok_next;

  // classify the incoming byte
  always_comb begin
    tok_next.digit = char_byte[3:0] - 4'd0;
    if (char_byte == 8'h00) begin
      tok_next.kind = TK_END;
    end else if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
      tok_next.kind = TK_DIGIT;
    end else if (char_byte == 8'h20 || (char_byte >= 8'h09 && char_byte <= 8'h0D)) begin
      tok_next.kind = TK_BLANK;
    end else if (char_byte == 8'h2B) begin
      tok_next.kind = TK_PLUS;
    end else if (char_byte == 8'h2D) begin
      tok_next.kind = TK_MINUS;
    end else begin
      tok_next.kind = TK_OTHER;
    end
  end

  // one-entry output register; refills in the cycle it drains
  assign char_ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (char_ready) begin
      tok_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      tok <= tok_next;
    end
  end

endmodule

FILE: sv/dsti_fifo.sv
// ----------------------------------------------------------------------------
// dsti_fifo: token queue between front and back
// Small register queue so front and back stall independently.
// ----------------------------------------------------------------------------
module dsti_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  dsti_pkg::tok_t push_tok,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dsti_pkg::tok_t pop_tok
);
  import dsti_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_tok    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

endmodule

FILE: sv/dsti_back.sv
// ----------------------------------------------------------------------------
// dsti_back: parse state and result register
// Walks the token stream, accumulates a saturating magnitude, and at end of
// string range-checks it and loads the result register.
// ----------------------------------------------------------------------------
module dsti_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         unsigned_mode,
  input  logic                         tok_valid,
  output logic                         tok_ready,
  input  dsti_pkg::tok_t               tok,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [dsti_pkg::VALUE_W-1:0] value_bits,
  output logic                         parse_ok
);
  import dsti_pkg::*;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_BAD    = 2'd3;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam int               ACC_W   = MAG_W + 4;

  logic [1:0]         phase, phase_next;
  logic               is_negative, is_negative_next;
  logic [MAG_W-1:0]   magnitude, magnitude_next;
  logic               overflowed, overflowed_next;
  logic               any_char_seen, any_char_seen_next;
  logic [ACC_W-1:0]   acc;
  logic               take;
  logic               is_end;
  logic               ok_base;
  logic               ok;
  logic [VALUE_W-1:0] mag_low;
  logic [VALUE_W-1:0] value_calc;

  // end tokens need the result slot; others always drain
  assign is_end    = (tok.kind == TK_END);
  assign tok_ready = !is_end || !result_valid || result_ready;
  assign take      = tok_valid && tok_ready;

  // magnitude * 10 + digit as shift-add
  assign acc = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} + ACC_W'(tok.digit);

  // next parse state
  always_comb begin
    phase_next         = phase;
    is_negative_next   = is_negative;
    magnitude_next     = magnitude;
    overflowed_next    = overflowed;
    any_char_seen_next = 1'b1;
    unique case (tok.kind)
      TK_END: begin
        phase_next         = PH_START;
        is_negative_next   = 1'b0;
        magnitude_next     = '0;
        overflowed_next    = 1'b0;
        any_char_seen_next = 1'b0;
      end
      TK_DIGIT: begin
        if (phase != PH_BAD) begin
          phase_next = PH_DIGITS;
          if (overflowed || acc > ACC_W'(MAG_MAX)) begin
            overflowed_next = 1'b1;
            magnitude_next  = MAG_MAX;
          end else begin
            magnitude_next = acc[MAG_W-1:0];
          end
        end
      end
      TK_BLANK: begin
        if (phase != PH_START) begin
          phase_next = PH_BAD;
        end
      end
      TK_PLUS, TK_MINUS: begin
        if (phase == PH_START) begin
          phase_next       = PH_SIGN;
          is_negative_next = (tok.kind == TK_MINUS);
        end else begin
          phase_next = PH_BAD;
        end
      end
      default: begin
        phase_next = PH_BAD;
      end
    endcase
  end

  // range check at end of string
  assign mag_low = magnitude[VALUE_W-1:0];
  assign ok_base = any_char_seen && (phase == PH_DIGITS) && !overflowed;

  always_comb begin
    if (unsigned_mode) begin
      if (is_negative) begin
        ok = ok_base && (magnitude == '0);
      end else begin
        ok = ok_base && !magnitude[MAG_W-1];
      end
    end else begin
      if (is_negative) begin
        ok = ok_base && (magnitude <= {2'b01, {(MAG_W-2){1'b0}}});
      end else begin
        ok = ok_base && (magnitude <= {2'b00, {(MAG_W-2){1'b1}}});
      end
    end
    if (!ok) begin
      value_calc = '0;
    end else if (is_negative) begin
      value_calc = '0 - mag_low;
    end else begin
      value_calc = mag_low;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      is_negative   <= 1'b0;
      magnitude     <= '0;
      overflowed    <= 1'b0;
      any_char_seen <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      is_negative   <= is_negative_next;
      magnitude     <= magnitude_next;
      overflowed    <= overflowed_next;
      any_char_seen <= any_char_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && is_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_end) begin
      value_bits <= value_calc;
      parse_ok   <= ok;
    end
  end

endmodule

FILE: sv/decimal_string_to_int_checked.sv
// ----------------------------------------------------------------------------
// decimal_string_to_int_checked: decimal ASCII to 32-bit integer with check
// Front classifier, token queue and back parser with result register.
// ----------------------------------------------------------------------------
// Takes one character per cycle while no unread result holds up the queue; a
// zero byte ends the string and yields one result (value_bits, parse_ok) once
// the terminator has passed the front register, the token queue and the result
// register in that order, each of which can stall on back-pressure.
// The rate is set by the back parser, which folds one digit per cycle into a
// 33-bit saturating magnitude with a single shift-add. Accepted format is
// optional blanks, an optional sign and one or more digits; failures return
// zero. unsigned_mode selects the signed or unsigned 32-bit range check and
// is read when the terminator is parsed; write it only while the block is
// idle. QUEUE_DEPTH sets the number of tokens buffered between the stages.
// ----------------------------------------------------------------------------
module decimal_string_to_int_checked #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic                         char_valid,
  output logic                         char_ready,
  input  logic [dsti_pkg::CHAR_W-1:0]  char_byte,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [dsti_pkg::VALUE_W-1:0] value_bits,
  output logic                         parse_ok
);
  import dsti_pkg::*;

  logic unsigned_mode;
  logic f_valid, f_ready;
  tok_t f_tok;
  logic q_valid, q_ready;
  tok_t q_tok;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      unsigned_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unsigned_mode <= cfg_wr_data;
    end
  end

  dsti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_byte  (char_byte),
    .tok_valid  (f_valid),
    .tok_ready  (f_ready),
    .tok        (f_tok)
  );

  dsti_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_tok    (q_tok)
  );

  dsti_back u_back (
    .clk           (clk),
    .rst           (rst),
    .unsigned_mode (unsigned_mode),
    .tok_valid     (q_valid),
    .tok_ready     (q_ready),
    .tok           (q_tok),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .value_bits    (value_bits),
    .parse_ok      (parse_ok)
  );

endmodule

FILE: verif/tb_decimal_string_to_int_checked.sv
// ----------------------------------------------------------------------------
// tb_decimal_string_to_int_checked: testbench for the decimal string parser
// Streams directed and random character strings through the valid/ready
// channel in both range modes, mirrors the parse state in a local predictor
// and checks value_bits and parse_ok of every result in order. The runs mix
// sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_decimal_string_to_int_checked;
  import dsti_pkg::*;

  // parse phases of the predictor
  typedef enum logic [1:0] {PH_START, PH_SIGN, PH_DIGITS, PH_BAD} parse_phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
  } conv_result_t;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // magnitude limits
  localparam logic [MAG_W-1:0] MAG_SAT     = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] S32_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [MAG_W-1:0] S32_NEG_MAX = 33'h0_8000_0000;
  localparam logic [MAG_W-1:0] U32_MAX     = 33'h0_FFFF_FFFF;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_wr_en    = 1'b0;
  logic                cfg_wr_data  = 1'b0;
  logic                char_valid   = 1'b0;
  logic                char_ready;
  logic [CHAR_W-1:0]   char_byte    = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [VALUE_W-1:0]  value_bits;
  logic                parse_ok;

  // stimulus control
  logic [CHAR_W-1:0]   char_queue[$];
  conv_result_t        expected_results[$];
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  logic                rx_hold       = 1'b0;
  int                  fail_count    = 0;

  // predictor state
  logic                p_unsigned = 1'b0;
  parse_phase_t        p_phase    = PH_START;
  logic                p_negative = 1'b0;
  logic [MAG_W-1:0]    p_mag      = '0;
  logic                p_overflow = 1'b0;
  logic                p_seen     = 1'b0;

  decimal_string_to_int_checked i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_byte    (char_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value_bits   (value_bits),
    .parse_ok     (parse_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // fold one accepted character into the parse state; terminator yields a result
  function automatic void parse_char(input logic [CHAR_W-1:0] c);
    logic [MAG_W+3:0] next_mag;
    conv_result_t     res;
    if (c != CH_NUL) begin
      p_seen = 1'b1;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (p_phase != PH_BAD) begin
          next_mag = p_mag;
          next_mag = next_mag * 10 + (c - CH_ZERO);
          if (p_overflow || next_mag > MAG_SAT) begin
            p_overflow = 1'b1;
            p_mag      = MAG_SAT;
          end else begin
            p_mag = next_mag[MAG_W-1:0];
          end
          p_phase = PH_DIGITS;
        end
      end else if (p_phase == PH_START &&
                   (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        // leading blanks leave the state as is
      end else if (p_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
        p_negative = (c == CH_MINUS);
        p_phase    = PH_SIGN;
      end else begin
        p_phase = PH_BAD;
      end
    end else begin
      res.ok = p_seen && p_phase == PH_DIGITS && !p_overflow;
      if (res.ok) begin
        if (p_unsigned) begin
          // minus zero is the only negative that passes
          res.ok = p_negative ? (p_mag == '0) : (p_mag <= U32_MAX);
        end else begin
          res.ok = p_negative ? (p_mag <= S32_NEG_MAX) : (p_mag <= S32_POS_MAX);
        end
      end
      res.value = '0;
      if (res.ok) begin
        res.value = p_mag[VALUE_W-1:0];
        if (p_negative) begin
          res.value = -res.value;
        end
      end
      expected_results.push_back(res);
      p_phase    = PH_START;
      p_negative = 1'b0;
      p_mag      = '0;
      p_overflow = 1'b0;
      p_seen     = 1'b0;
    end
  endfunction

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ready) begin
      if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        char_valid <= 1'b1;
        char_byte  <= char_queue.pop_front();
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // predict on every accepted character
  always @(posedge clk) begin
    if (!rst && char_valid && char_ready) begin
      parse_char(char_byte);
    end
  end

  // result receiver with random stalls and hold-off
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    conv_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value_bits %h parse_ok %b", value_bits, parse_ok);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (value_bits !== want.value) begin
          $error("value_bits: expected %h, got %h", want.value, value_bits);
          fail_count++;
        end
        if (parse_ok !== want.ok) begin
          $error("parse_ok: expected %b, got %b", want.ok, parse_ok);
          fail_count++;
        end
      end
    end
  end

  // range mode write, only while the block is idle
  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    p_unsigned   = m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // wait until all characters are taken and all results are back
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (char_queue.size() > 0 || char_valid || expected_results.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_queue.push_back(s[i]);
    end
    char_queue.push_back(CH_NUL);
  endtask

  task automatic directed_strings();
    push_text("");
    push_text("0");
    push_text("-0");
    push_text("-000");
    push_text("+5");
    // every blank kind ahead of the digits
    for (logic [CHAR_W-1:0] c = CH_TAB; c <= CH_CR; c++) begin
      char_queue.push_back(c);
    end
    char_queue.push_back(CH_SPACE);
    push_text("42");
    push_text("2147483647");
    push_text("-2147483648");
    push_text("2147483648");
    push_text("-2147483649");
    push_text("4294967295");
    push_text("4294967296");
    push_text("-4294967295");
    push_text("8589934591");
    push_text("8589934592");
    push_text("99999999999999999999");
    push_text("-");
    push_text("+");
    push_text("   ");
    push_text("- 5");
    push_text("12a");
    push_text("1 ");
    push_text("+-3");
    push_text("00012");
    char_queue.push_back(8'hFF);
    push_text("7");
  endtask

  // one random string with terminator; returns the number of characters
  function automatic int push_random_string();
    logic [CHAR_W-1:0] s[$];
    longint unsigned   mag;
    longint unsigned   base;
    string             digits;
    int                kind;
    int                k;
    int                sign_end;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      // plain noise
      repeat ($urandom_range(0, 6)) s.push_back(CHAR_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        k = $urandom_range(0, 5);
        s.push_back(k == 5 ? CH_SPACE : CHAR_W'(CH_TAB + k));
      end
      case ($urandom_range(2))
        1: s.push_back(CH_PLUS);
        2: s.push_back(CH_MINUS);
        default: ;
      endcase
      sign_end = s.size();
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) s.push_back(CH_ZERO);
      end
      case ($urandom_range(7))
        0, 1: mag = $urandom_range(0, 999);
        2:    mag = $urandom;
        3:    mag = longint'($urandom) + (longint'($urandom_range(0, 1)) << 32);
        4: begin
          // around the range and saturation edges
          case ($urandom_range(3))
            0:       base = 64'h0;
            1:       base = 64'h8000_0000;
            2:       base = 64'h1_0000_0000;
            default: base = 64'h2_0000_0000;
          endcase
          mag = base + $urandom_range(0, 4);
          if (base >= 2) begin
            mag = mag - 2;
          end
        end
        5:       mag = {$urandom, $urandom};
        6:       mag = $urandom_range(0, 99999);
        default: mag = $urandom_range(0, 9);
      endcase
      digits = $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++) begin
        s.push_back(digits[i]);
      end
      // broken strings
      if (kind >= 70) begin
        case ($urandom_range(3))
          0: begin
            s.insert(sign_end, CH_SPACE);
            s.insert(sign_end, $urandom_range(1) ? CH_PLUS : CH_MINUS);
          end
          1: s.push_back(CHAR_W'($urandom_range(1, 255)));
          2: s.insert($urandom_range(0, s.size()), CHAR_W'($urandom_range(1, 255)));
          default: begin
            while (s.size() > sign_end) begin
              void'(s.pop_back());
            end
          end
        endcase
      end
    end
    foreach (s[i]) begin
      char_queue.push_back(s[i]);
    end
    char_queue.push_back(CH_NUL);
    return s.size() + 1;
  endfunction

  task automatic run_random(input logic m, input int idle, input int stall,
                            input int n_chars, input bit hold_rx);
    int sent;
    write_mode(m);
    send_idle_pct = idle;
    stall_pct     = stall;
    sent          = 0;
    if (hold_rx) begin
      // receiver holds off while the sender keeps offering
      fork
        begin
          @(posedge clk);
          rx_hold <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          rx_hold <= 1'b0;
        end
      join_none
    end
    while (sent < n_chars) begin
      sent += push_random_string();
    end
    wait_idle();
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mode(1'b0);
    directed_strings();
    wait_idle();
    write_mode(1'b1);
    directed_strings();
    wait_idle();

    run_random(1'b0, 0, 0, 140, 1'b0);
    run_random(1'b1, 57, 0, 140, 1'b0);
    run_random(1'b0, 0, 57, 140, 1'b0);
    run_random(1'b1, 33, 33, 140, 1'b0);
    run_random(1'b0, 33, 33, 140, 1'b1);
    run_random(1'b1, 0, 0, 70, 1'b0);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
